>>> design/qsd_pkg.sv
// Shared types and constants for the byte-serial QOI chunk decoder.
// No dependencies; the front end, queue, back end and top level import it.

package qsd_pkg;

  // configuration port
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // full-byte opcodes and two-bit op tags
  localparam logic [7:0] OP_RGB_BYTE  = 8'hFE;
  localparam logic [7:0] OP_RGBA_BYTE = 8'hFF;
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  // channel arithmetic constants (mod 256)
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] DIFF_BIAS    = 8'd254;
  localparam logic [7:0] LUMA_G_BIAS  = 8'd224;
  localparam logic [7:0] LUMA_RB_BIAS = 8'd8;

  // op still collecting operand bytes
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RGB  = 2'd1,
    PEND_RGBA = 2'd2,
    PEND_LUMA = 2'd3
  } pend_e;

  // one pixel, element 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][7:0] rgba_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic        last_of_item;
    logic        frame_done;
  } out_item_t;

  // decoded command from front to back: pixel repeated count times
  typedef struct packed {
    logic [15:0] pixel;
    logic [5:0]  count;
    logic        done;
  } cmd_t;

endpackage

>>> design/qsd_front.sv
// Front end: byte intake, op decode, pixel state, hash index and clipping.
// Depends on qsd_pkg; feeds decoded commands into qsd_fifo.

module qsd_front
  import qsd_pkg::*;
#(
  parameter int unsigned Depth  = 4,
  parameter int unsigned LevelW = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  in_item_t            in_item_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [LevelW-1:0]   fifo_level_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o
);

  function automatic logic [5:0] rgba_hash(input rgba_t p);
    rgba_hash = p[0][5:0] * 6'd3 + p[1][5:0] * 6'd5 + p[2][5:0] * 6'd7
              + p[3][5:0] * 6'd11;
  endfunction

  function automatic logic [15:0] rgb565_swapped(input rgba_t p);
    logic [15:0] v;
    v = {p[0][7:3], p[1][7:2], p[2][7:3]};
    rgb565_swapped = {v[7:0], v[15:8]};
  endfunction

  // configuration and frame size product
  logic [15:0] width_q, height_q;
  logic [31:0] total_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      total_q  <= '0;
    end else if (cfg_we) begin
      if (cfg_addr_i == CFG_FRAME_WIDTH) begin
        width_q <= cfg_wdata_i;
        total_q <= {16'd0, cfg_wdata_i} * {16'd0, height_q};
      end else begin
        height_q <= cfg_wdata_i;
        total_q  <= {16'd0, width_q} * {16'd0, cfg_wdata_i};
      end
    end
  end

  // intake stage: the byte is held in a register while the index read completes
  logic     accept;
  logic     s0_v_q;
  in_item_t s0_q;

  assign accept = push_i && !full_o;
  assign full_o = ({1'b0, fifo_level_i} + {{LevelW{1'b0}}, s0_v_q})
                  >= (LevelW + 1)'(Depth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_q <= in_item_i;
    end
  end

  // pixel state
  rgba_t       pix_q, pix_d;
  pend_e       pend_q, pend_d;
  logic [2:0]  await_q, await_d;
  logic [5:0]  dg_q, dg_d;
  logic [31:0] emitted_q, emitted_d;

  // hash index memory with per-entry valid bits
  rgba_t       idx_mem [64];
  rgba_t       rdata_q;
  logic [63:0] idx_valid_q, idx_valid_d;
  logic        fwd_hit_q;
  rgba_t       fwd_data_q;
  logic        idx_we;
  logic [5:0]  idx_waddr;

  always_ff @(posedge clk_i) begin
    if (idx_we) begin
      idx_mem[idx_waddr] <= pix_d;
    end
    if (accept) begin
      rdata_q <= idx_mem[in_item_i.data_byte[5:0]];
    end
    fwd_data_q <= pix_d;
  end

  // read that meets a write at the same edge takes the written pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= idx_we && (idx_waddr == in_item_i.data_byte[5:0]);
    end
  end

  // frame start clears every valid bit, a write then marks its entry
  always_comb begin
    idx_valid_d = idx_valid_q;
    if (s0_v_q && s0_q.frame_start) begin
      idx_valid_d = '0;
    end
    if (idx_we) begin
      idx_valid_d[idx_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_valid_q <= '0;
    end else begin
      idx_valid_q <= idx_valid_d;
    end
  end

  // decode of the held byte
  rgba_t       pix_base, entry;
  pend_e       pend_base;
  logic [2:0]  await_base, need;
  logic [5:0]  dg_base;
  logic [31:0] emitted_base, remaining;
  logic [7:0]  b, vg;
  logic [1:0]  pos;
  logic        frame_full, emit, done;
  logic [5:0]  count, clipped;

  always_comb begin
    b = s0_q.data_byte;
    if (s0_q.frame_start) begin
      pix_base     = {ALPHA_OPAQUE, 8'd0, 8'd0, 8'd0};
      pend_base    = PEND_NONE;
      await_base   = '0;
      dg_base      = '0;
      emitted_base = '0;
      entry        = '0;
    end else begin
      pix_base     = pix_q;
      pend_base    = pend_q;
      await_base   = await_q;
      dg_base      = dg_q;
      emitted_base = emitted_q;
      if (fwd_hit_q) begin
        entry = fwd_data_q;
      end else if (idx_valid_q[b[5:0]]) begin
        entry = rdata_q;
      end else begin
        entry = '0;
      end
    end

    frame_full = emitted_base >= total_q;
    pix_d      = pix_base;
    pend_d     = pend_base;
    await_d    = await_base;
    dg_d       = dg_base;
    emit       = 1'b0;
    count      = 6'd1;
    vg         = {2'b00, dg_base} + LUMA_G_BIAS;
    need       = (pend_base == PEND_RGBA) ? 3'd4 : 3'd3;
    pos        = 2'(need - await_base);

    if (!frame_full) begin
      if (pend_base == PEND_LUMA) begin
        pix_d[0] = pix_base[0] + vg - LUMA_RB_BIAS + {4'd0, b[7:4]};
        pix_d[1] = pix_base[1] + vg;
        pix_d[2] = pix_base[2] + vg - LUMA_RB_BIAS + {4'd0, b[3:0]};
        await_d  = '0;
        pend_d   = PEND_NONE;
        emit     = 1'b1;
      end else if (pend_base != PEND_NONE) begin
        // operand byte of a full-color op
        pix_d[pos] = b;
        await_d    = await_base - 3'd1;
        if (await_d == 3'd0) begin
          pend_d = PEND_NONE;
          emit   = 1'b1;
        end
      end else if (b == OP_RGB_BYTE) begin
        pend_d  = PEND_RGB;
        await_d = 3'd3;
      end else if (b == OP_RGBA_BYTE) begin
        pend_d  = PEND_RGBA;
        await_d = 3'd4;
      end else begin
        unique case (b[7:6])
          TAG_INDEX: begin
            pix_d = entry;
            emit  = 1'b1;
          end
          TAG_DIFF: begin
            pix_d[0] = pix_base[0] + {6'd0, b[5:4]} + DIFF_BIAS;
            pix_d[1] = pix_base[1] + {6'd0, b[3:2]} + DIFF_BIAS;
            pix_d[2] = pix_base[2] + {6'd0, b[1:0]} + DIFF_BIAS;
            emit     = 1'b1;
          end
          TAG_LUMA: begin
            pend_d  = PEND_LUMA;
            await_d = 3'd1;
            dg_d    = b[5:0];
          end
          default: begin
            count = b[5:0] + 6'd1;
            emit  = 1'b1;
          end
        endcase
      end
    end

    // clip the pixel count at the frame size
    remaining = total_q - emitted_base;
    done      = (remaining[31:6] == '0) && (count >= remaining[5:0]);
    clipped   = done ? remaining[5:0] : count;
    emitted_d = emitted_base;
    if (emit) begin
      emitted_d = done ? total_q : emitted_base + 32'(count);
    end

    idx_waddr   = rgba_hash(pix_d);
    idx_we      = s0_v_q && emit;
    cmd_valid_o = s0_v_q && emit;
    cmd_o.pixel = rgb565_swapped(pix_d);
    cmd_o.count = clipped;
    cmd_o.done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q     <= {ALPHA_OPAQUE, 8'd0, 8'd0, 8'd0};
      pend_q    <= PEND_NONE;
      await_q   <= '0;
      dg_q      <= '0;
      emitted_q <= '0;
    end else if (s0_v_q) begin
      pix_q     <= pix_d;
      pend_q    <= pend_d;
      await_q   <= await_d;
      dg_q      <= dg_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

>>> design/qsd_fifo.sv
// Short command queue between the decode front end and the pixel back end.
// Depends on qsd_pkg for the command type.

module qsd_fifo
  import qsd_pkg::*;
#(
  parameter int unsigned Depth  = 4,
  parameter int unsigned LevelW = $clog2(Depth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  cmd_t              wr_cmd_i,
  input  logic              rd_en_i,
  output cmd_t              rd_cmd_o,
  output logic              empty_o,
  output logic [LevelW-1:0] level_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t              slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [LevelW-1:0] level_q;

  assign empty_o  = (level_q == '0);
  assign level_o  = level_q;
  assign rd_cmd_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slots_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        level_q <= level_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  // the front end must never overrun the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && !rd_en_i |-> level_q < LevelW'(Depth))
    else $error("command queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o)
    else $error("command queue underflow");

endmodule

>>> design/qsd_back.sv
// Back end: expands each command into its run of pixels, one per cycle while pop is held.
// Depends on qsd_pkg; drains qsd_fifo and drives the result port.

module qsd_back
  import qsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fifo_empty_i,
  input  cmd_t      fifo_cmd_i,
  output logic      fifo_rd_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  logic        act_v_q;
  logic [15:0] pix_q;
  logic [5:0]  left_q;
  logic        done_q;
  logic        last, take, pop_ok;

  assign last     = (left_q == 6'd1);
  assign pop_ok   = pop_i && act_v_q;
  assign take     = !fifo_empty_i && (!act_v_q || (pop_ok && last));
  assign fifo_rd_o = take;

  assign empty_o                 = !act_v_q;
  assign out_item_o.pixel_rgb565 = pix_q;
  assign out_item_o.last_of_item = last;
  assign out_item_o.frame_done   = last && done_q;

  // active command and remaining pixels of its run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_v_q <= 1'b0;
      left_q  <= '0;
    end else if (take) begin
      act_v_q <= 1'b1;
      left_q  <= fifo_cmd_i.count;
    end else if (pop_ok) begin
      left_q <= left_q - 6'd1;
      if (last) begin
        act_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pix_q  <= fifo_cmd_i.pixel;
      done_q <= fifo_cmd_i.done;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_v_q |-> left_q != 6'd0)
    else $error("active run with no pixels left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok && !last |=> act_v_q && $stable(pix_q))
    else $error("run cut short before its last pixel");

endmodule

>>> design/qsd_top_dummy_placeholder.sv
// The registered result port of the decoder is held in qsd_back; this file
// carries no code, and the pixel-format helper sits in qsd_front.

>>> design/qoi_stream_decoder_rgb565.sv
// QOI chunk-stream decoder with byte-swapped RGB565 pixel output. Compressed
// bytes are accepted at one per cycle while full is low; a byte that completes
// a pixel passes the intake register and hash index read, is then decoded into
// the command queue, and then moves from the queue to the output register.
// Each decoded pixel stays on the output until it is popped, so a run byte of n
// pixels holds the result port for n pops while input keeps flowing until the
// FifoDepth-entry command queue fills; sustained input rate is then set by the
// pixel count per byte. The 64-entry hash index uses per-entry valid bits, so
// frame_start clears it at once and no clearing pass is needed after reset.
// Depends on qsd_pkg, qsd_front, qsd_fifo and qsd_back.

module qoi_stream_decoder_rgb565
  import qsd_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i
);

  localparam int unsigned LevelW = $clog2(FifoDepth + 1);

  logic              cmd_valid, fifo_rd, fifo_empty;
  cmd_t              cmd, head_cmd;
  logic [LevelW-1:0] fifo_level;

  // decode front end
  qsd_front #(
    .Depth  (FifoDepth),
    .LevelW (LevelW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .in_item_i    (in_item_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fifo_level_i (fifo_level),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  // command queue
  qsd_fifo #(
    .Depth  (FifoDepth),
    .LevelW (LevelW)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmd_valid),
    .wr_cmd_i (cmd),
    .rd_en_i  (fifo_rd),
    .rd_cmd_o (head_cmd),
    .empty_o  (fifo_empty),
    .level_o  (fifo_level)
  );

  // pixel run back end
  qsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_cmd_i   (head_cmd),
    .fifo_rd_o    (fifo_rd),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_item_o   (out_item_o)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the byte-serial QOI chunk decoder with RGB565 output.
// Depends on qsd_pkg and the qoi_stream_decoder_rgb565 top level.

module tb_top;
  import qsd_pkg::*;

  localparam int unsigned IdlePct     = 6;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxStall    = 2000;
  localparam int unsigned TargetBytes = 360;
  localparam int unsigned MaxOps      = 30;
  localparam int unsigned MaxPrinted  = 40;

  // expected pixel stream, kept in step with every accepted request
  class pixel_scoreboard;
    logic [15:0] width;
    logic [15:0] height;
    rgba_t       px;
    rgba_t       slots [64];
    pend_e       pend;
    logic [2:0]  awaited;
    logic [5:0]  luma_dg;
    logic [31:0] emitted;
    logic [5:0]  recent_slot [4];
    int unsigned recent_wr;
    out_item_t   want_pixels [$];
    int unsigned errors;
    int unsigned decoded;
    int unsigned ignored;
    int unsigned checked;

    function new();
      width     = '0;
      height    = '0;
      recent_wr = 0;
      errors    = 0;
      decoded   = 0;
      ignored   = 0;
      checked   = 0;
      foreach (recent_slot[i]) recent_slot[i] = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      px    = '0;
      px[3] = ALPHA_OPAQUE;
      foreach (slots[i]) slots[i] = '0;
      pend    = PEND_NONE;
      awaited = '0;
      luma_dg = '0;
      emitted = '0;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] addr, logic [15:0] val);
      if (addr == CFG_FRAME_WIDTH) width = val;
      else if (addr == CFG_FRAME_HEIGHT) height = val;
    endfunction

    function logic [31:0] frame_size();
      return 32'(width) * 32'(height);
    endfunction

    function bit frame_full();
      return emitted >= frame_size();
    endfunction

    // rgb565 word with its two bytes swapped
    function logic [15:0] pack_565_swapped(rgba_t p);
      logic [15:0] w;
      w = {p[0][7:3], p[1][7:2], p[2][7:3]};
      return {w[7:0], w[15:8]};
    endfunction

    // decode one accepted byte; returns 0 when the block must ignore it
    function bit decode_byte(in_item_t req);
      logic [7:0]  b;
      logic [7:0]  dg;
      logic [5:0]  slot;
      logic [31:0] total;
      int unsigned count;
      int unsigned pos;
      int unsigned h;
      out_item_t   want;
      b = req.data_byte;
      if (req.frame_start) clear_frame();
      total = frame_size();
      if (emitted >= total) begin
        ignored++;
        return 1'b0;
      end
      decoded++;
      count = 0;
      if (pend != PEND_NONE) begin
        // operand byte of a multi-byte op
        if (pend == PEND_LUMA) begin
          dg    = {2'b00, luma_dg} - 8'd32;
          px[0] = px[0] + dg - 8'd8 + {4'b0000, b[7:4]};
          px[1] = px[1] + dg;
          px[2] = px[2] + dg - 8'd8 + {4'b0000, b[3:0]};
          awaited = '0;
        end else begin
          pos = ((pend == PEND_RGBA) ? 4 : 3) - 32'(awaited);
          px[pos % 4] = b;
          awaited = awaited - 3'd1;
        end
        if (awaited == '0) begin
          pend  = PEND_NONE;
          count = 1;
        end
      end else if (b == OP_RGB_BYTE) begin
        pend    = PEND_RGB;
        awaited = 3'd3;
      end else if (b == OP_RGBA_BYTE) begin
        pend    = PEND_RGBA;
        awaited = 3'd4;
      end else begin
        case (b[7:6])
          TAG_INDEX: begin
            px    = slots[b[5:0]];
            count = 1;
          end
          TAG_DIFF: begin
            px[0] = px[0] + {6'b000000, b[5:4]} - 8'd2;
            px[1] = px[1] + {6'b000000, b[3:2]} - 8'd2;
            px[2] = px[2] + {6'b000000, b[1:0]} - 8'd2;
            count = 1;
          end
          TAG_LUMA: begin
            pend    = PEND_LUMA;
            awaited = 3'd1;
            luma_dg = b[5:0];
          end
          default: begin
            count = 32'(b[5:0]) + 1;
          end
        endcase
      end
      if (count == 0) return 1'b1;

      // hash index update
      h = 32'(px[0]) * 3 + 32'(px[1]) * 5 + 32'(px[2]) * 7 + 32'(px[3]) * 11;
      slot = h[5:0];
      slots[slot] = px;
      recent_slot[recent_wr % 4] = slot;
      recent_wr++;

      // clip at the frame size
      if (count > total - emitted) count = total - emitted;
      for (int unsigned k = 0; k < count; k++) begin
        emitted++;
        want.pixel_rgb565 = pack_565_swapped(px);
        want.last_of_item = (k + 1 == count);
        want.frame_done   = (emitted == total);
        want_pixels.push_back(want);
      end
      return 1'b1;
    endfunction

    // print the first few mismatches, count all of them
    task report(string msg);
      if (errors < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_pixel(out_item_t got);
      out_item_t want;
      if (want_pixels.size() == 0) begin
        report($sformatf("pixel %h with nothing expected", got.pixel_rgb565));
      end else begin
        want = want_pixels.pop_front();
        if (got.pixel_rgb565 !== want.pixel_rgb565)
          report($sformatf("pixel %0d: rgb565 got %h want %h", checked,
                           got.pixel_rgb565, want.pixel_rgb565));
        if (got.last_of_item !== want.last_of_item)
          report($sformatf("pixel %0d: last_of_item got %b want %b", checked,
                           got.last_of_item, want.last_of_item));
        if (got.frame_done !== want.frame_done)
          report($sformatf("pixel %0d: frame_done got %b want %b", checked,
                           got.frame_done, want.frame_done));
        checked++;
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  in_item_t            req_item = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_item_t           pixel_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr = CFG_FRAME_WIDTH;
  logic [15:0]         cfg_wdata = '0;

  pixel_scoreboard sb = new();
  bit              idle_en = 1'b1;
  bit              start_pending = 1'b0;
  int unsigned     stall_cycles = 0;
  int unsigned     phase_no = 0;

  qoi_stream_decoder_rgb565 uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_item_i   (req_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (pixel_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random pop stalls, check on every accepted pixel
  always @(negedge clk) begin
    pop <= !(idle_en && $urandom_range(99) < IdlePct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_pixel(pixel_item);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= MaxStall) begin
      $display("watchdog: no progress for %0d cycles", stall_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request, held until taken
  task automatic send_byte(input logic fs, input logic [7:0] b);
    in_item_t req;
    req.data_byte   = b;
    req.frame_start = fs;
    @(negedge clk);
    while (idle_en && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push     <= 1'b1;
    req_item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    void'(sb.decode_byte(req));
  endtask

  // next byte, carrying a pending frame start
  task automatic emit(input logic [7:0] b);
    send_byte(start_pending, b);
    start_pending = 1'b0;
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [15:0] val);
    @(negedge clk);
    push      <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(addr, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every expected pixel, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.want_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one well-formed op with random content, or a stray byte now and then
  task automatic random_op();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(99);
    if (roll < 5) begin
      start_pending = start_pending || ($urandom_range(7) == 0);
      emit(8'($urandom));
    end else if (roll < 18) begin
      emit(OP_RGB_BYTE);
      repeat (3) emit(8'($urandom));
    end else if (roll < 30) begin
      emit(OP_RGBA_BYTE);
      repeat (4) emit(8'($urandom));
    end else if (roll < 48) begin
      if ($urandom_range(1) == 0) emit({TAG_INDEX, sb.recent_slot[$urandom_range(3)]});
      else emit({TAG_INDEX, 6'($urandom)});
    end else if (roll < 66) begin
      emit({TAG_DIFF, 6'($urandom)});
    end else if (roll < 80) begin
      emit({TAG_LUMA, 6'($urandom)});
      emit(8'($urandom));
    end else begin
      len = ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(61);
      emit({TAG_RUN, 6'(len)});
    end
  endtask

  // new geometry, then a few frames of random ops
  task automatic run_phase(input logic [15:0] w, input logic [15:0] h, input int unsigned frames);
    int unsigned ops;
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    for (int unsigned f = 0; f < frames; f++) begin
      start_pending = (f > 0) || ($urandom_range(3) != 0);
      ops = 0;
      do begin
        random_op();
        ops++;
      end while (ops < MaxOps && !sb.frame_full());
      // trailing bytes, dropped once the frame is full
      repeat ($urandom_range(2)) emit(8'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: 4x5 frame, every op, field extremes, wrap, clipping, full frame
    write_reg(CFG_FRAME_WIDTH, 16'd4);
    write_reg(CFG_FRAME_HEIGHT, 16'd5);
    send_byte(1'b1, 8'h00);                 // index of a cleared slot
    send_byte(1'b0, OP_RGB_BYTE);
    send_byte(1'b0, 8'h12);
    send_byte(1'b0, 8'h34);
    send_byte(1'b0, 8'h56);
    send_byte(1'b0, OP_RGBA_BYTE);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, 8'h7F);
    send_byte(1'b0, {TAG_DIFF, 6'h00});     // all channels -2, green wraps
    send_byte(1'b0, {TAG_DIFF, 6'h3F});     // all channels +1
    send_byte(1'b0, {TAG_LUMA, 6'h00});     // smallest luma step
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, {TAG_LUMA, 6'h3F});     // largest luma step
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, {TAG_INDEX, 6'h3F});
    send_byte(1'b0, {TAG_RUN, 6'd0});       // single pixel run
    send_byte(1'b0, {TAG_RUN, 6'd5});
    send_byte(1'b0, {TAG_RUN, 6'd61});      // longest run, clipped at frame end
    send_byte(1'b0, 8'h12);                 // ignored, frame full
    send_byte(1'b0, OP_RGB_BYTE);           // ignored, frame full
    send_byte(1'b1, OP_RGB_BYTE);           // new frame opens an rgb op
    send_byte(1'b0, 8'h1F);

    // random phases: big frames without idling first, then degenerate and small sizes
    while (sb.decoded < TargetBytes) begin
      idle_en = (phase_no != 0);
      case (phase_no)
        0:       run_phase(16'hFFFF, 16'hFFFF, 3);
        1:       run_phase(16'd1, 16'd1, 4);
        2:       run_phase(16'd0, 16'd9, 1);
        3:       run_phase(16'hFFFF, 16'd0, 1);
        4:       run_phase(16'd1, 16'hFFFF, 2);
        default: run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                           $urandom_range(1, 3));
      endcase
      phase_no++;
    end

    @(negedge clk);
    push <= 1'b0;
    wait_idle();

    $display("covered %0d decoded bytes and %0d dropped bytes over %0d geometry phases",
             sb.decoded, sb.ignored, phase_no + 1);
    $display("checked %0d pixels, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
design/qsd_pkg.sv
design/qsd_front.sv
design/qsd_fifo.sv
design/qsd_back.sv
design/qsd_top_dummy_placeholder.sv
design/qoi_stream_decoder_rgb565.sv
tb/tb_top.sv
